// ===== sv/iso2022cn_stream_encoder_macros.svh =====
// Assertion macros for the ISO-2022-CN stream encoder.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ISO2022CN_STREAM_ENCODER_MACROS_SVH
`define ISO2022CN_STREAM_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2cn_pkg.sv =====
// Shared types and constants for the ISO-2022-CN stream encoder.
// No dependencies.
`default_nettype none

package i2cn_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int RUN_MAX = 8;
    localparam int IDX_W   = $clog2(RUN_MAX);

    localparam logic [2:0] CS_ASCII  = 3'd0;
    localparam logic [2:0] CS_GB2312 = 3'd1;
    localparam logic [2:0] CS_CNS1   = 3'd2;
    localparam logic [2:0] CS_CNS2   = 3'd3;
    localparam logic [2:0] CS_NONE   = 3'd7;

    localparam logic [1:0] G1_NONE   = 2'd0;
    localparam logic [1:0] G1_GB2312 = 2'd1;
    localparam logic [1:0] G1_CNS1   = 2'd2;
    localparam logic [1:0] G1_BAD    = 2'd3;

    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_DOLLAR  = 8'h24;
    localparam logic [7:0] BYTE_TO_G1   = 8'h29;
    localparam logic [7:0] BYTE_TO_G2   = 8'h2A;
    localparam logic [7:0] BYTE_SS2     = 8'h4E;
    localparam logic [7:0] BYTE_SO      = 8'h0E;
    localparam logic [7:0] BYTE_SI      = 8'h0F;
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_FIN_GB  = 8'h41;
    localparam logic [7:0] BYTE_FIN_CNS1 = 8'h47;
    localparam logic [7:0] BYTE_FIN_CNS2 = 8'h48;

    // one character's byte run, byte 0 goes out first
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]        last_idx;
    } run_t;

    typedef struct packed {
        logic [1:0] g1_designation;
        logic       g2_holds_plane2;
        logic       shifted_out;
    } front_status_t;

endpackage

`default_nettype wire

// ===== sv/iso2022cn_stream_encoder.sv =====
// The first byte of a run is valid once the run has been written into the queue and
// then loaded into the back end's run register. Throughput: one output byte per cycle
// while m_tready is high; a character's run is 1 to 8 bytes. Input accepts every cycle
// while the run queue has room. Other charsets are accepted and produce nothing.
// Reset (rst_n low, async) clears the G1/G2/shift state, empties the queue.
`default_nettype none

`include "iso2022cn_stream_encoder_macros.svh"

module iso2022cn_stream_encoder
    import i2cn_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_set[2:0], first_byte[10:3], second_byte[18:11]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast
);

    run_t          fr_run, q_run;
    logic          fr_push, q_ready, q_valid, q_pop;
    front_status_t fr_status;

    i2cn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .char_set    (s_tdata[2:0]),
        .first_byte  (s_tdata[10:3]),
        .second_byte (s_tdata[18:11]),
        .q_ready     (q_ready),
        .push        (fr_push),
        .run         (fr_run),
        .status      (fr_status)
    );

    i2cn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fr_push),
        .wr_run   (fr_run),
        .wr_ready (q_ready),
        .pop      (q_pop),
        .rd_run   (q_run),
        .rd_valid (q_valid)
    );

    i2cn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_run     (q_run),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

    `I2CN_ASSERT_NOW(a_push_has_room, clk, rst_n, fr_push, q_ready, "push into full queue")
    `I2CN_ASSERT_NOW(a_shift_needs_g1, clk, rst_n, fr_status.shifted_out,
        fr_status.g1_designation == G1_GB2312 || fr_status.g1_designation == G1_CNS1,
        "shifted out without G1 designation")
    `I2CN_ASSERT_NEXT(a_idle_after_last, clk, rst_n, m_tvalid && m_tready && m_tlast && !q_valid,
        !m_tvalid, "output valid with no queued run")

endmodule

`default_nettype wire

// ===== sv/i2cn_front.sv =====
// Front end: accepts characters, tracks G1/G2/shift state and builds byte runs.
// Depends on i2cn_pkg.
`default_nettype none

module i2cn_front
    import i2cn_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [2:0]    char_set,
    input  wire logic [7:0]    first_byte,
    input  wire logic [7:0]    second_byte,
    input  wire logic          q_ready,
    output logic               push,
    output run_t               run,
    output front_status_t      status
);

    logic [1:0] g1_reg, g1_next;
    logic       g2_reg, g2_next;
    logic       so_reg, so_next;
    logic [2:0] gl;
    logic [3:0] n;
    logic       cs_ok;
    logic       take;

    assign in_ready = q_ready;
    assign cs_ok    = (char_set <= CS_CNS2);
    assign take     = in_valid && q_ready && cs_ok;
    assign push     = take;
    assign status   = '{g1_designation: g1_reg, g2_holds_plane2: g2_reg, shifted_out: so_reg};

    always_comb
    begin
        if (!so_reg)
            gl = CS_ASCII;
        else if (g1_reg == G1_GB2312)
            gl = CS_GB2312;
        else if (g1_reg == G1_CNS1)
            gl = CS_CNS1;
        else
            gl = CS_NONE;
    end

    always_comb
    begin
        g1_next   = g1_reg;
        g2_next   = g2_reg;
        so_next   = so_reg;
        run.bytes = '0;
        n         = 4'd0;

        if (char_set == gl)
        begin
            if (char_set == CS_ASCII && first_byte == BYTE_NEWLINE)
            begin
                g1_next = G1_NONE;
                g2_next = 1'b0;
            end
        end
        else if (char_set == CS_CNS2)
        begin
            if (!g2_reg)
            begin
                run.bytes[0] = BYTE_ESC;
                run.bytes[1] = BYTE_DOLLAR;
                run.bytes[2] = BYTE_TO_G2;
                run.bytes[3] = BYTE_FIN_CNS2;
                n            = 4'd4;
                g2_next      = 1'b1;
            end
            run.bytes[n[IDX_W-1:0]]        = BYTE_ESC;
            run.bytes[n[IDX_W-1:0] + 3'd1] = BYTE_SS2;
            n = n + 4'd2;
        end
        else if (char_set == CS_GB2312 || char_set == CS_CNS1)
        begin
            if (g1_reg != ((char_set == CS_GB2312) ? G1_GB2312 : G1_CNS1))
            begin
                run.bytes[0] = BYTE_ESC;
                run.bytes[1] = BYTE_DOLLAR;
                run.bytes[2] = BYTE_TO_G1;
                run.bytes[3] = (char_set == CS_GB2312) ? BYTE_FIN_GB : BYTE_FIN_CNS1;
                n            = 4'd4;
                g1_next      = (char_set == CS_GB2312) ? G1_GB2312 : G1_CNS1;
            end
            run.bytes[n[IDX_W-1:0]] = BYTE_SO;
            n       = n + 4'd1;
            so_next = 1'b1;
        end
        else
        begin
            run.bytes[0] = BYTE_SI;
            n            = 4'd1;
            if (first_byte == BYTE_NEWLINE)
            begin
                g1_next = G1_NONE;
                g2_next = 1'b0;
            end
            so_next = 1'b0;
        end

        run.bytes[n[IDX_W-1:0]] = first_byte;
        n = n + 4'd1;
        if (char_set != CS_ASCII)
        begin
            run.bytes[n[IDX_W-1:0]] = second_byte;
            n = n + 4'd1;
        end
        run.last_idx = IDX_W'(n - 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg <= G1_NONE;
            g2_reg <= 1'b0;
            so_reg <= 1'b0;
        end
        else if (take)
        begin
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            so_reg <= so_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cn_queue.sv =====
// Short queue of byte runs between the front end and the byte sequencer.
// Depends on i2cn_pkg.
`default_nettype none

module i2cn_queue
    import i2cn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t wr_run,
    output logic      wr_ready,
    input  wire logic pop,
    output run_t      rd_run,
    output logic      rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    run_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_run   = slots_reg[rd_ptr_reg];
    assign do_push  = push && wr_ready;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= wr_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cn_back.sv =====
// Back end: sends a queued run one byte per ready cycle, tagging the last.
// Depends on i2cn_pkg.
`default_nettype none

module i2cn_back
    import i2cn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire run_t       q_run,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    run_t             run_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             fire;
    logic             done;

    assign out_valid = busy_reg;
    assign out_byte  = run_reg.bytes[idx_reg];
    assign out_last  = (idx_reg == run_reg.last_idx);
    assign fire      = busy_reg && out_ready;
    assign done      = fire && out_last;
    assign q_pop     = q_valid && (!busy_reg || done);

    always_ff @(posedge clk)
    begin
        if (q_pop)
            run_reg <= q_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire
